// ===== hw/rtl/dnle_pkg.sv =====
`timescale 1ns / 1ps

package dnle_pkg;

    // Input action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Byte values with a fixed meaning in the wire form
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] TERMINATOR = 8'h00;

    // Counter widths: a label never exceeds 63, a name never exceeds 255
    localparam int LBL_W  = 6;
    localparam int NAME_W = 8;
    localparam int OFS_W  = 9;

    // Depth of the result queue in front of the output channel
    localparam int RQ_DEPTH = 4;

    // One result word
    typedef struct packed {
        logic             write_enable;
        logic [7:0]       out_byte;
        logic [OFS_W-1:0] out_offset;
        logic             name_done;
        logic             name_ok;
    } t_result;

    // Result queue write strobes
    typedef struct packed {
        logic wr_first;
        logic wr_second;
    } t_push;

endpackage

// ===== hw/rtl/dnle_in_if.sv =====
`timescale 1ns / 1ps

interface dnle_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

// ===== hw/rtl/dnle_out_if.sv =====
`timescale 1ns / 1ps

interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic       write_enable;
    logic [7:0] out_byte;
    logic [8:0] out_offset;
    logic       name_done;
    logic       name_ok;

    modport source (output valid, output write_enable, output out_byte, output out_offset,
                    output name_done, output name_ok, input ready);
    modport sink   (input valid, input write_enable, input out_byte, input out_offset,
                    input name_done, input name_ok, output ready);
endinterface

// ===== hw/rtl/dnle_rq.sv =====
`timescale 1ns / 1ps

module dnle_rq import dnle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room2,
    dnle_out_if.source o_out
);

    localparam int AW = $clog2(RQ_DEPTH);

    t_result         r_mem [RQ_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    logic [AW:0]     n_count;
    logic [AW:0]     w_push_cnt;
    logic            w_pop;

    assign w_pop      = o_out.valid && o_out.ready;
    assign w_push_cnt = (AW+1)'(i_push.wr_first) + (AW+1)'(i_push.wr_second);
    assign n_count    = r_count + w_push_cnt - (AW+1)'(w_pop);

    // Store up to two words per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.wr_first) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push.wr_second) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_res1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(w_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    // Room for a full end-of-name pair even if nothing drains
    assign o_room2 = (r_count <= (AW+1)'(RQ_DEPTH - 2));

    // Present the head word
    assign o_out.valid        = (r_count != '0);
    assign o_out.write_enable = r_mem[r_rd_ptr].write_enable;
    assign o_out.out_byte     = r_mem[r_rd_ptr].out_byte;
    assign o_out.out_offset   = r_mem[r_rd_ptr].out_offset;
    assign o_out.name_done    = r_mem[r_rd_ptr].name_done;
    assign o_out.name_ok      = r_mem[r_rd_ptr].name_ok;

endmodule

// ===== hw/rtl/dns_name_label_encoder.sv =====
`timescale 1ns / 1ps

// DNS name encoder: dotted name in, wire-format byte writes out.
// Input channel i_in carries one word per name character (action = char)
// or an end-of-name word (action = end, char_code ignored). Output channel
// o_out carries byte writes: out_byte goes to out_offset of the buffer when
// write_enable is set. Each character or dot gives one word; the end word
// gives two (the last label's length, then the zero terminator flagged
// with name_done and name_ok).
// A word accepted on the input is registered, then encoded and written into
// the result queue, from which its first result is offered.
// Throughput: one input word per cycle while the queue has room for an
// end-of-name pair; an end word's two results leave by the single-word port.
// A four-word result queue decouples the sides: input stays ready while
// results wait, and ready drops only once the queue cannot take a full
// end-of-name pair. A stalled receiver holds the head word unchanged.
// Reset empties the queue, drops the input register and clears all label
// and name counters; encoding state also returns to reset after each end.
module dns_name_label_encoder import dnle_pkg::*; #(
    parameter int MAX_NAME  = 255,
    parameter int MAX_LABEL = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnle_in_if.sink    i_in,
    dnle_out_if.source o_out
);

    localparam logic [NAME_W-1:0] NAME_LIM  = NAME_W'(MAX_NAME);
    localparam logic [LBL_W-1:0]  LABEL_LIM = LBL_W'(MAX_LABEL);

    logic              r_in_valid;
    logic              r_in_action;
    logic [7:0]        r_in_char;

    logic [NAME_W-1:0] r_label_start, n_label_start;
    logic [LBL_W-1:0]  r_label_length, n_label_length;
    logic [NAME_W-1:0] r_name_length, n_name_length;
    logic              r_name_failed, n_name_failed;

    logic              w_room2;
    logic              w_advance;
    logic              w_is_dot;
    logic              w_fail_name;
    logic              w_fail_label;
    t_push             w_push;
    t_result           w_res0;
    t_result           w_res1;

    assign w_advance  = r_in_valid && w_room2;
    assign i_in.ready = !r_in_valid || w_room2;

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_action <= i_in.action;
            r_in_char   <= i_in.char_code;
        end
    end

    // Limit checks: the name limit covers dots, the label limit only characters
    assign w_is_dot     = (r_in_char == DOT_CHAR);
    assign w_fail_name  = r_name_failed || (r_name_length >= NAME_LIM);
    assign w_fail_label = w_fail_name || (!w_is_dot && (r_label_length >= LABEL_LIM));

    // Encode one word and update counters
    always_comb begin
        n_label_start  = r_label_start;
        n_label_length = r_label_length;
        n_name_length  = r_name_length;
        n_name_failed  = r_name_failed;
        w_push         = '0;
        w_res0         = '0;
        w_res1         = '0;
        if (w_advance) begin
            w_push.wr_first = 1'b1;
            if (r_in_action == ACT_END) begin
                w_push.wr_second = 1'b1;
                w_res1.name_done = 1'b1;
                if (!r_name_failed) begin
                    w_res0.write_enable = 1'b1;
                    w_res0.out_byte     = 8'(r_label_length);
                    w_res0.out_offset   = OFS_W'(r_label_start);
                    w_res1.write_enable = 1'b1;
                    w_res1.out_byte     = TERMINATOR;
                    w_res1.out_offset   = OFS_W'(r_name_length) + OFS_W'(1);
                    w_res1.name_ok      = 1'b1;
                end
                n_label_start  = '0;
                n_label_length = '0;
                n_name_length  = '0;
                n_name_failed  = 1'b0;
            end else begin
                n_name_failed = w_fail_label;
                if (!w_fail_label) begin
                    w_res0.write_enable = 1'b1;
                    n_name_length       = r_name_length + NAME_W'(1);
                    if (w_is_dot) begin
                        w_res0.out_byte   = 8'(r_label_length);
                        w_res0.out_offset = OFS_W'(r_label_start);
                        n_label_start     = r_name_length + NAME_W'(1);
                        n_label_length    = '0;
                    end else begin
                        w_res0.out_byte   = r_in_char;
                        w_res0.out_offset = OFS_W'(r_name_length) + OFS_W'(1);
                        n_label_length    = r_label_length + LBL_W'(1);
                    end
                end
            end
        end
    end

    // Hold encoding state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_start  <= '0;
            r_label_length <= '0;
            r_name_length  <= '0;
            r_name_failed  <= 1'b0;
        end else begin
            r_label_start  <= n_label_start;
            r_label_length <= n_label_length;
            r_name_length  <= n_name_length;
            r_name_failed  <= n_name_failed;
        end
    end

    dnle_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .o_room2 (w_room2),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/dnle_checker.sv =====
`timescale 1ns / 1ps

module dnle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_write_enable,
    input logic [7:0] i_out_byte,
    input logic [8:0] i_out_offset,
    input logic       i_name_done,
    input logic       i_name_ok
);

    // ok is only reported together with the end of a name
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_name_ok && !i_name_done))
        else $error("name_ok without name_done");

    // Suppressed words carry a zero byte and offset
    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_write_enable) |-> (i_out_byte == 8'h00 && i_out_offset == 9'd0))
        else $error("suppressed word carries data");

    // A written terminator never lands on the first slot
    a_term_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_name_done && i_write_enable) |-> (i_out_offset != 9'd0))
        else $error("terminator at offset zero");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)
            && $stable(i_out_offset) && $stable(i_write_enable) && $stable(i_name_done)))
        else $error("stalled output word changed");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_write_enable (o_out.write_enable),
    .i_out_byte     (o_out.out_byte),
    .i_out_offset   (o_out.out_offset),
    .i_name_done    (o_out.name_done),
    .i_name_ok      (o_out.name_ok)
);
